// ----- rtl/core/coet_pkg.sv -----
// Shared widths, codes and types for the clock offset exchange tracker.
package coet_pkg;

	localparam int unsigned TS_W      = 63;
	localparam int unsigned DIFF_W    = 64;
	localparam int unsigned ID_W      = 32;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned ELAPSED_W = 17;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned STATUS_W  = 3;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
	localparam logic [TICK_W-1:0]    TIMEOUT_RESET = TICK_W'(100);

	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_RESP  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IDLE    = 3'd0,
		ST_SENT    = 3'd1,
		ST_SEEN    = 3'd2,
		ST_VALID   = 3'd3,
		ST_INVALID = 3'd4,
		ST_TIMEOUT = 3'd5
	} status_t;

endpackage

// ----- rtl/core/coet_in_if.sv -----
// Request channel carrying one timestamp event into the tracker.
interface coet_in_if;
	logic                        valid;
	logic                        ready;
	logic [coet_pkg::OP_W-1:0]   op;
	logic [coet_pkg::TS_W-1:0]   now_ns;
	logic [coet_pkg::ID_W-1:0]   resp_id;
	logic [coet_pkg::TS_W-1:0]   resp_t1_ns;
	logic [coet_pkg::TS_W-1:0]   resp_t2_ns;
	logic [coet_pkg::TS_W-1:0]   resp_t3_ns;
	logic                        resp_well_formed;

	modport source (
		output valid, op, now_ns, resp_id, resp_t1_ns, resp_t2_ns, resp_t3_ns,
			resp_well_formed,
		input ready
	);
	modport sink (
		input valid, op, now_ns, resp_id, resp_t1_ns, resp_t2_ns, resp_t3_ns,
			resp_well_formed,
		output ready
	);
endinterface

// ----- rtl/core/coet_out_if.sv -----
// Result channel carrying the tracker state after each request.
interface coet_out_if;
	logic                              valid;
	logic                              ready;
	logic [coet_pkg::STATUS_W-1:0]     status;
	logic                              busy_res;
	logic                              send_request;
	logic [coet_pkg::ID_W-1:0]         req_seq;
	logic [coet_pkg::TS_W-1:0]         request_t1_ns;
	logic signed [coet_pkg::DIFF_W-1:0] offset_half_ns;
	logic signed [coet_pkg::DIFF_W-1:0] rtt_ns;
	logic                              have_offset;

	modport source (
		output valid, status, busy_res, send_request, req_seq, request_t1_ns,
			offset_half_ns, rtt_ns, have_offset,
		input ready
	);
	modport sink (
		input valid, status, busy_res, send_request, req_seq, request_t1_ns,
			offset_half_ns, rtt_ns, have_offset,
		output ready
	);
endinterface

// ----- rtl/core/clock_offset_exchange_tracker.sv -----
// Top level of the four-timestamp clock offset exchange tracker.
//
// Follows one NTP-style exchange at a time. A start request issues a new id
// and stamps t1; a response request carrying the echoed id and t1 plus the
// remote t2/t3 is checked against the pending request and, when it matches,
// yields offset = (t2-t1)+(t3-t4) in half-nanoseconds and delay =
// (t4-t1)-(t3-t2) in nanoseconds, all modulo 2^64. Tick requests age a pending
// request and time it out once the elapsed count exceeds timeout_q.
// Every request yields exactly one result showing the state after it.
// Throughput is one request per cycle while results are taken; an input
// stage forms the four timestamp differences, then a second stage adds them,
// updates the tracker state and loads the result register. The result
// register lets a new request enter while a finished result waits.
module clock_offset_exchange_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [coet_pkg::TICK_W-1:0]   cfg_wdata,
	coet_in_if.sink                       in_ch,
	coet_out_if.source                    out_ch
);

	// Configuration
	logic [coet_pkg::TICK_W-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= coet_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Stage 1: capture the request and form the timestamp differences
	logic                          valid_s1;
	logic [coet_pkg::OP_W-1:0]     op_s1;
	logic [coet_pkg::TS_W-1:0]     now_s1;
	logic [coet_pkg::ID_W-1:0]     rid_s1;
	logic [coet_pkg::TS_W-1:0]     rt1_s1;
	logic                          well_s1;
	logic [coet_pkg::DIFF_W-1:0]   d21_s1;
	logic [coet_pkg::DIFF_W-1:0]   d34_s1;
	logic [coet_pkg::DIFF_W-1:0]   d41_s1;
	logic [coet_pkg::DIFF_W-1:0]   d32_s1;

	logic out_valid_q;
	logic advance;
	logic take_in;

	// Stage 1 moves on whenever the result register is free or being drained.
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || !out_valid_q || out_ch.ready;
	assign take_in      = in_ch.valid && in_ch.ready;

	logic [coet_pkg::DIFF_W-1:0] t1_x, t2_x, t3_x, t4_x;
	assign t1_x = {1'b0, in_ch.resp_t1_ns};
	assign t2_x = {1'b0, in_ch.resp_t2_ns};
	assign t3_x = {1'b0, in_ch.resp_t3_ns};
	assign t4_x = {1'b0, in_ch.now_ns};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1   <= in_ch.op;
			now_s1  <= in_ch.now_ns;
			rid_s1  <= in_ch.resp_id;
			rt1_s1  <= in_ch.resp_t1_ns;
			well_s1 <= in_ch.resp_well_formed;
			// Differences use the echoed t1; it must equal the pending t1 to count.
			d21_s1  <= t2_x - t1_x;
			d34_s1  <= t3_x - t4_x;
			d41_s1  <= t4_x - t1_x;
			d32_s1  <= t3_x - t2_x;
		end
	end

	// Tracker state
	logic                            in_flight_q;
	logic [coet_pkg::ID_W-1:0]       pending_id_q;
	logic [coet_pkg::TS_W-1:0]       pending_t1_q;
	logic [coet_pkg::ELAPSED_W-1:0]  elapsed_q;
	coet_pkg::status_t               status_q;
	logic [coet_pkg::DIFF_W-1:0]     last_offset_q;
	logic [coet_pkg::DIFF_W-1:0]     last_delay_q;
	logic                            offset_seen_q;

	logic                            in_flight_d;
	logic [coet_pkg::ID_W-1:0]       pending_id_d;
	logic [coet_pkg::TS_W-1:0]       pending_t1_d;
	logic [coet_pkg::ELAPSED_W-1:0]  elapsed_d;
	coet_pkg::status_t               status_d;
	logic [coet_pkg::DIFF_W-1:0]     last_offset_d;
	logic [coet_pkg::DIFF_W-1:0]     last_delay_d;
	logic                            offset_seen_d;
	logic                            sent_d;
	logic [coet_pkg::ELAPSED_W-1:0]  elapsed_inc;

	assign elapsed_inc = (elapsed_q < coet_pkg::ELAPSED_MAX) ?
		elapsed_q + coet_pkg::ELAPSED_W'(1) : elapsed_q;

	// Stage 2: apply the request to the tracker state
	always_comb begin
		in_flight_d   = in_flight_q;
		pending_id_d  = pending_id_q;
		pending_t1_d  = pending_t1_q;
		elapsed_d     = elapsed_q;
		status_d      = status_q;
		last_offset_d = last_offset_q;
		last_delay_d  = last_delay_q;
		offset_seen_d = offset_seen_q;
		sent_d        = 1'b0;
		case (op_s1)
			coet_pkg::OP_START: begin
				// Ignore a start while a request is still out.
				if (!in_flight_q) begin
					pending_id_d = pending_id_q + coet_pkg::ID_W'(1);
					pending_t1_d = now_s1;
					elapsed_d    = '0;
					in_flight_d  = 1'b1;
					status_d     = coet_pkg::ST_SENT;
					sent_d       = 1'b1;
				end
			end
			coet_pkg::OP_RESP: begin
				if (in_flight_q) begin
					status_d = coet_pkg::ST_SEEN;
					if (!well_s1) begin
						in_flight_d = 1'b0;
						status_d    = coet_pkg::ST_INVALID;
					end else if (rid_s1 == pending_id_q) begin
						if (rt1_s1 != pending_t1_q) begin
							in_flight_d = 1'b0;
							status_d    = coet_pkg::ST_INVALID;
						end else begin
							last_offset_d = d21_s1 + d34_s1;
							last_delay_d  = d41_s1 - d32_s1;
							offset_seen_d = 1'b1;
							in_flight_d   = 1'b0;
							status_d      = coet_pkg::ST_VALID;
							pending_t1_d  = '0;
							elapsed_d     = '0;
						end
					end
					// Stale id: keep the request pending.
				end
			end
			coet_pkg::OP_TICK: begin
				if (in_flight_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > {1'b0, timeout_q}) begin
						in_flight_d = 1'b0;
						status_d    = coet_pkg::ST_TIMEOUT;
					end
				end
			end
			default: begin
				// Unused op: report the state unchanged.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q   <= 1'b0;
			pending_id_q  <= '0;
			pending_t1_q  <= '0;
			elapsed_q     <= '0;
			status_q      <= coet_pkg::ST_IDLE;
			last_offset_q <= '0;
			last_delay_q  <= '0;
			offset_seen_q <= 1'b0;
		end else if (advance) begin
			in_flight_q   <= in_flight_d;
			pending_id_q  <= pending_id_d;
			pending_t1_q  <= pending_t1_d;
			elapsed_q     <= elapsed_d;
			status_q      <= status_d;
			last_offset_q <= last_offset_d;
			last_delay_q  <= last_delay_d;
			offset_seen_q <= offset_seen_d;
		end
	end

	// Result register
	logic [coet_pkg::STATUS_W-1:0]    res_status_q;
	logic                             res_busy_q;
	logic                             res_sent_q;
	logic [coet_pkg::ID_W-1:0]        res_id_q;
	logic [coet_pkg::TS_W-1:0]        res_t1_q;
	logic [coet_pkg::DIFF_W-1:0]      res_offset_q;
	logic [coet_pkg::DIFF_W-1:0]      res_delay_q;
	logic                             res_have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_status_q <= status_d;
			res_busy_q   <= in_flight_d;
			res_sent_q   <= sent_d;
			res_id_q     <= pending_id_d;
			res_t1_q     <= pending_t1_d;
			res_offset_q <= last_offset_d;
			res_delay_q  <= last_delay_d;
			res_have_q   <= offset_seen_d;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = res_status_q;
	assign out_ch.busy_res       = res_busy_q;
	assign out_ch.send_request   = res_sent_q;
	assign out_ch.req_seq        = res_id_q;
	assign out_ch.request_t1_ns  = res_t1_q;
	assign out_ch.offset_half_ns = $signed(res_offset_q);
	assign out_ch.rtt_ns         = $signed(res_delay_q);
	assign out_ch.have_offset    = res_have_q;

endmodule
